FILE: rtl/hbr_pkg.sv
package hbr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;  // Q2.16 coefficients, signed
  localparam int FRAC_BITS = 16;
  // Sum of |coef| times full-scale input stays below 2^33; one spare bit
  // keeps the rounding add safe.
  localparam int ACC_W     = 35;

  localparam int DOWN_TAPS = 43;
  localparam int UP_TAPS   = 42;
  localparam int N_CELLS   = (DOWN_TAPS > UP_TAPS) ? DOWN_TAPS : UP_TAPS;

  localparam int DOWN_ADV  = (DOWN_TAPS + 1) / 2 - 1;
  localparam int UP_ADV    = (UP_TAPS + 1) / 2 - 1;
  localparam int DOWN_FULL = DOWN_ADV + 1;
  localparam int UP_FULL   = UP_ADV + 1;
  localparam int UP_FLUSH  = UP_ADV + 1;
  localparam int DOWN_FLUSH = DOWN_ADV;

  localparam int MAX_FULL  = (DOWN_FULL > UP_FULL) ? DOWN_FULL : UP_FULL;
  localparam int MAX_FLUSH = (DOWN_FLUSH > UP_FLUSH) ? DOWN_FLUSH : UP_FLUSH;
  localparam int FILL_W    = $clog2(MAX_FULL + 1);
  localparam int PEND_W    = $clog2(MAX_FLUSH + 1);

  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_arr_t [N_CELLS];

  localparam coef_arr_t DOWN_COEF = '{
    18'sd0, 18'sd0, 18'sd0, -18'sd69, 18'sd0, 18'sd164, 18'sd0, -18'sd321,
    18'sd0, 18'sd560, 18'sd0, -18'sd916, 18'sd0, 18'sd1443, 18'sd0,
    -18'sd2249, 18'sd0, 18'sd3622, 18'sd0, -18'sd6611, 18'sd0, 18'sd20745,
    18'sd32768,
    18'sd20745, 18'sd0, -18'sd6611, 18'sd0, 18'sd3622, 18'sd0, -18'sd2249,
    18'sd0, 18'sd1443, 18'sd0, -18'sd916, 18'sd0, 18'sd560, 18'sd0,
    -18'sd321, 18'sd0, 18'sd164, 18'sd0, -18'sd69, 18'sd0
  };

  // The interpolation filter has one tap less; the last cell gets zero.
  localparam coef_arr_t UP_COEF = '{
    18'sd0, 18'sd0, -18'sd138, 18'sd0, 18'sd329, 18'sd0, -18'sd641, 18'sd0,
    18'sd1121, 18'sd0, -18'sd1833, 18'sd0, 18'sd2885, 18'sd0, -18'sd4499,
    18'sd0, 18'sd7243, 18'sd0, -18'sd13223, 18'sd0, 18'sd41489,
    18'sd65536,
    18'sd41489, 18'sd0, -18'sd13223, 18'sd0, 18'sd7243, 18'sd0, -18'sd4499,
    18'sd0, 18'sd2885, 18'sd0, -18'sd1833, 18'sd0, 18'sd1121, 18'sd0,
    -18'sd641, 18'sd0, 18'sd329, 18'sd0, -18'sd138, 18'sd0,
    18'sd0
  };

  typedef enum logic {
    MODE_DOWN = 1'b0,
    MODE_UP   = 1'b1
  } mode_t;

  typedef struct packed {
    logic push;  // one sample enters the cell chain this cycle
    logic emit;  // the sum produced by this push is a result
    logic last;  // that result ends the stream
    logic clr;   // return all cells to zero
  } seq_ctl_t;

endpackage

FILE: rtl/halfband_resampler_2x_core.sv
// Factor-of-two half-band resampler. With cfg resample_mode at 0 it
// decimates (43-tap filter, one result per two inputs) and takes one input
// per cycle unless stalled; at 1 it interpolates (42-tap filter on the
// zero-stuffed stream), follows each input with a stuffed zero and gives
// two results per input. The filter is a transposed chain of 43
// multiply-add cells taking one sample (input or stuffed zero) per cycle
// unless stalled. An input with in_last set is followed by 21 zero pushes
// that flush the remaining results, the final one carrying out_last, after
// which the chain is cleared for the next stream. A result is registered
// in the head cell and then written to a four-entry output queue, so a
// stalled output side holds up the input only once that queue is full. A
// write to resample_mode drops any stream in progress.
module halfband_resampler_2x_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hbr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hbr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last
);
  import hbr_pkg::*;

  mode_t                   mode;
  seq_ctl_t                ctl;
  logic signed [SAMPLE_W-1:0] push_x;
  logic                    room;
  logic signed [ACC_W-1:0] sums [N_CELLS];

  hbr_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .room        (room),
    .in_stall    (in_stall),
    .mode        (mode),
    .ctl         (ctl),
    .push_x      (push_x)
  );

  // Cell k adds its tap to the partial sum coming from cell k+1; the head
  // cell then holds the full filter output of the latest push.
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    logic signed [ACC_W-1:0] sum_in;
    coef_t                   coef;

    if (k == N_CELLS - 1) begin : g_tail
      assign sum_in = '0;
    end else begin : g_mid
      assign sum_in = sums[k+1];
    end

    assign coef = (mode == MODE_UP) ? UP_COEF[k] : DOWN_COEF[k];

    hbr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (ctl.clr),
      .shift   (ctl.push),
      .coef    (coef),
      .x       (push_x),
      .sum_in  (sum_in),
      .sum_out (sums[k])
    );
  end

  hbr_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .acc        (sums[0]),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .out_last   (out_last),
    .room       (room)
  );

endmodule

FILE: rtl/hbr_cell.sv
module hbr_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             shift,
  input  hbr_pkg::coef_t                   coef,
  input  logic signed [hbr_pkg::SAMPLE_W-1:0] x,
  input  logic signed [hbr_pkg::ACC_W-1:0]    sum_in,
  output logic signed [hbr_pkg::ACC_W-1:0]    sum_out
);
  import hbr_pkg::*;

  logic signed [COEF_W+SAMPLE_W-1:0] prod;
  logic signed [ACC_W-1:0]           sum_nxt;
  logic signed [ACC_W-1:0]           sum_r;

  assign prod    = coef * x;
  assign sum_nxt = ACC_W'(prod) + sum_in;
  assign sum_out = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sum_r <= '0;
    end else if (shift) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

FILE: rtl/hbr_seq.sv
module hbr_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_valid,
  input  logic signed [hbr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  input  logic                                room,
  output logic                                in_stall,
  output hbr_pkg::mode_t                      mode,
  output hbr_pkg::seq_ctl_t                   ctl,
  output logic signed [hbr_pkg::SAMPLE_W-1:0] push_x
);
  import hbr_pkg::*;

  mode_t             mode_r, mode_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              phase_r, phase_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              flush_r, flush_nxt;
  logic              clr_r, clr_nxt;

  logic              zero_push;
  logic              in_xfer;
  logic              push;
  logic              is_up;
  logic [FILL_W-1:0] full_c;
  logic [FILL_W-1:0] fill_new;
  logic              phase_new;
  logic [PEND_W-1:0] pend_after;
  logic              flush_after;
  logic              emit;
  logic              last;
  logic              final_push;

  assign is_up     = (mode_r == MODE_UP);
  // Pending zero pushes go first; a new sample waits until they are done.
  assign zero_push = (pend_r != '0) && room && !clr_r;
  assign in_stall  = !((pend_r == '0) && room && !clr_r);
  assign in_xfer   = in_valid && !in_stall;
  assign push      = zero_push || in_xfer;
  assign push_x    = zero_push ? '0 : in_sample;

  always_comb begin
    full_c    = is_up ? FILL_W'(UP_FULL) : FILL_W'(DOWN_FULL);
    fill_new  = (fill_r < full_c) ? fill_r + FILL_W'(1) : fill_r;
    phase_new = ~phase_r;
    if (zero_push) begin
      pend_after  = pend_r - PEND_W'(1);
      flush_after = flush_r;
    end else if (in_last) begin
      pend_after  = is_up ? PEND_W'(UP_FLUSH) : PEND_W'(DOWN_FLUSH);
      flush_after = 1'b1;
    end else begin
      pend_after  = is_up ? PEND_W'(1) : '0;
      flush_after = 1'b0;
    end
    if (is_up) begin
      emit = (fill_new == full_c);
    end else begin
      emit = (fill_new == full_c) && (phase_new == 1'(DOWN_FULL % 2));
    end
    // Decimation emits on every other push only, so a result one push
    // before the end of the flush is already the final one.
    last = flush_after && emit &&
           ((pend_after == '0) || (!is_up && (pend_after == PEND_W'(1))));
    final_push = push && flush_after && (pend_after == '0);
  end

  always_comb begin
    mode_nxt  = mode_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    flush_nxt = flush_r;
    clr_nxt   = 1'b0;
    if (cfg_wr_en) begin
      mode_nxt  = cfg_wr_data ? MODE_UP : MODE_DOWN;
      fill_nxt  = '0;
      phase_nxt = 1'b0;
      pend_nxt  = '0;
      flush_nxt = 1'b0;
    end else if (push) begin
      fill_nxt  = final_push ? '0 : fill_new;
      phase_nxt = final_push ? 1'b0 : phase_new;
      pend_nxt  = pend_after;
      flush_nxt = final_push ? 1'b0 : flush_after;
      clr_nxt   = final_push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DOWN;
      fill_r  <= '0;
      phase_r <= 1'b0;
      pend_r  <= '0;
      flush_r <= 1'b0;
      clr_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      flush_r <= flush_nxt;
      clr_r   <= clr_nxt;
    end
  end

  assign mode     = mode_r;
  assign ctl.push = push;
  assign ctl.emit = emit;
  assign ctl.last = last;
  // The chain clears in the cycle after the final push so that its sum can
  // still be read from the head cell.
  assign ctl.clr  = clr_r || cfg_wr_en;

endmodule

FILE: rtl/hbr_outq.sv
module hbr_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hbr_pkg::seq_ctl_t                   ctl,
  input  logic signed [hbr_pkg::ACC_W-1:0]    acc,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [hbr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_last,
  output logic                                room
);
  import hbr_pkg::*;

  localparam int Q_W = ACC_W - FRAC_BITS;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } q_entry_t;

  logic                 wr_r;
  logic                 last_r;
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  q_entry_t             q_mem [Q_DEPTH];

  logic signed [ACC_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;
  logic                    pos_ovf;
  logic                    neg_ovf;
  logic signed [SAMPLE_W-1:0] sat;
  logic                    pop;

  // Round half up, then floor by the coefficient scale.
  assign rnd = acc + ACC_W'(1 << (FRAC_BITS - 1));
  assign q   = rnd[ACC_W-1:FRAC_BITS];
  assign pos_ovf = !q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '0);
  assign neg_ovf =  q[Q_W-1] && (q[Q_W-2:SAMPLE_W-1] != '1);

  always_comb begin
    if (pos_ovf) begin
      sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_ovf) begin
      sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat = q[SAMPLE_W-1:0];
    end
  end

  assign out_valid  = (cnt_r != '0);
  assign out_sample = q_mem[rd_ptr_r].sample;
  assign out_last   = q_mem[rd_ptr_r].last;
  assign pop        = out_valid && !out_stall;
  // A push now lands in the queue in the next cycle; count it against the room.
  assign room       = (cnt_r + Q_CNT_W'(wr_r)) < Q_CNT_W'(Q_DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_r ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(wr_r) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_r     <= ctl.push && ctl.emit;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= ctl.last;
    if (wr_r) begin
      q_mem[wr_ptr_r] <= '{sample: sat, last: last_r};
    end
  end

endmodule

FILE: rtl/hbr_checker.sv
module hbr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_wr_en,
  input logic                                cfg_wr_data,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_last,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [hbr_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_last
);

  logic up_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      up_mode_r <= cfg_wr_data;
    end
  end

  // A waiting result keeps its value until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_last))
    else $error("result changed while stalled");

  // After a final input, or any input while interpolating, zero samples
  // must be pushed next, so no input transfer can follow at once.
  a_zero_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !cfg_wr_en && (in_last || up_mode_r) |=> in_stall)
    else $error("input taken while zero samples were still due");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind halfband_resampler_2x_core hbr_checker u_hbr_checker (.*);
